// File: hw/rtl/positional_source_gain_macros.svh
// Assertion macros shared by the checker file.
// Both expect a clock named i_clk in scope; PSG_ASSERT also expects an active-low reset named i_rst_n.
`ifndef POSITIONAL_SOURCE_GAIN_MACROS_SVH
`define POSITIONAL_SOURCE_GAIN_MACROS_SVH

// Property checked outside reset.
`define PSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PSG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/psg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

    // Fixed field widths.
    localparam int REF_W   = 31;
    localparam int ROLL_W  = 16;
    localparam int PAN_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MVOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MLEV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd2;

    // Pan gain works in Q.16 regardless of the gain format.
    localparam int PAN_SHIFT = 16;
    localparam int PG_W      = 17;
    localparam logic [PG_W:0] PAN_ONE = 18'd65536;

    // Audible threshold: t * 10000 must reach unity.
    localparam int AUD_SCALE_W = 14;
    localparam logic [AUD_SCALE_W-1:0] AUD_SCALE = 14'd10000;

endpackage

`default_nettype wire

// File: hw/rtl/psg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one source and listener description per request.
interface psg_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] src_x;
    logic signed [COORD_WIDTH-1:0] src_y;
    logic signed [COORD_WIDTH-1:0] src_z;
    logic signed [COORD_WIDTH-1:0] lis_x;
    logic signed [COORD_WIDTH-1:0] lis_y;
    logic signed [COORD_WIDTH-1:0] lis_z;
    logic [psg_pkg::REF_W-1:0]     ref_distance;
    logic [psg_pkg::ROLL_W-1:0]    rolloff;
    logic [FRAC_BITS:0]            min_level;
    logic [FRAC_BITS:0]            max_level;
    logic [FRAC_BITS:0]            src_volume;
    logic signed [psg_pkg::PAN_W-1:0] pan;

    modport source (
        output valid, src_x, src_y, src_z, lis_x, lis_y, lis_z,
        output ref_distance, rolloff, min_level, max_level, src_volume, pan,
        input  ready
    );
    modport sink (
        input  valid, src_x, src_y, src_z, lis_x, lis_y, lis_z,
        input  ref_distance, rolloff, min_level, max_level, src_volume, pan,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/psg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: channel gains and the audible flag.
interface psg_out_if #(
    parameter int FRAC_BITS = 16
) ();
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] left_gain;
    logic [FRAC_BITS:0] right_gain;
    logic               audible;

    modport source (output valid, left_gain, right_gain, audible, input ready);
    modport sink   (input valid, left_gain, right_gain, audible, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/positional_source_gain.sv
// Per-source gain for positional audio.
// i_req carries one request per source: source and listener positions,
// reference distance, rolloff, level limits, volume and pan. o_res returns
// one result per request, in order: left and right gain and an audible flag.
// Both channels use valid/ready; a request moves when both are high.
// The configuration port writes master volume, master level and stereo mode
// at any edge where i_cfg_we is high; write it only while the block is idle.
// Throughput is one request per cycle while the output is not stalled. The
// pipeline has three stages that form the squared distance, one stage per root
// bit for the square root, two stages that form the divisor, one stage per
// quotient bit for the divider, then clamp, three gain multiplies, the pan
// multiply and the output register.
// The whole pipeline advances together: while a result waits at the output
// and o_res.ready is low, every stage holds and i_req.ready is low.
// Synchronous reset empties the pipeline and restores master volume and
// level to unity and stereo mode on.
`timescale 1ns / 1ps
`default_nettype none

module positional_source_gain #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    psg_in_if.sink             i_req,
    psg_out_if.source          o_res,
    input  wire logic          i_cfg_we,
    input  wire logic [psg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FRAC_BITS:0]            i_cfg_data
);

    localparam int G_W    = FRAC_BITS + 1;
    localparam int D_W    = COORD_WIDTH + 1;
    localparam int S_W    = 2 * D_W;
    localparam int R_W    = D_W;
    localparam int RM_W   = R_W + 3;
    localparam int REF_W  = psg_pkg::REF_W;
    localparam int ROLL_W = psg_pkg::ROLL_W;
    localparam int CMP_W  = (R_W > REF_W) ? R_W : REF_W;
    localparam int PROD_W = R_W + ROLL_W;
    localparam int BASE_W = REF_W + 8;
    localparam int DEN_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
    localparam int NUM_W  = REF_W + 8 + FRAC_BITS;
    localparam int DIV_W  = (NUM_W > DEN_W + FRAC_BITS + 1) ? NUM_W : DEN_W + FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int T1_W   = G_W + 1;
    localparam int T2_W   = G_W + 2;
    localparam int T3_W   = G_W + 3;
    localparam int A_W    = T3_W + psg_pkg::AUD_SCALE_W;
    localparam int GP_W   = T3_W + psg_pkg::PG_W;
    localparam int NSTG   = R_W + Q_W + 11;

    localparam logic [G_W-1:0]  UNITY    = G_W'(2 ** FRAC_BITS);
    localparam logic [G_W-1:0]  MAX_GAIN = G_W'(3 * (2 ** (FRAC_BITS - 1)));

    typedef struct packed {
        logic [REF_W-1:0]         rdist;
        logic [ROLL_W-1:0]        roll;
        logic [G_W-1:0]           lo;
        logic [G_W-1:0]           hi;
        logic [G_W-1:0]           vol;
        logic [psg_pkg::PAN_W-1:0] pan;
    } t_side;

    logic            en;
    logic [NSTG-1:0] r_v;

    // Configuration registers.
    logic [G_W-1:0] r_mvol;
    logic [G_W-1:0] r_mlev;
    logic           r_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvol   <= UNITY;
            r_mlev   <= UNITY;
            r_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psg_pkg::CFG_MVOL:   r_mvol   <= i_cfg_data;
                psg_pkg::CFG_MLEV:   r_mlev   <= i_cfg_data;
                psg_pkg::CFG_STEREO: r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a result is stuck at the output.
    assign en          = !r_v[NSTG-1] || o_res.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_req.valid};
        end
    end

    // Stage 1: absolute axis gaps.
    logic [D_W-1:0] n_gap [3];
    logic [D_W-1:0] r_gap [3];
    t_side          n_side0;
    t_side          r_side1;
    logic [COORD_WIDTH-1:0] n_a [3];
    logic [COORD_WIDTH-1:0] n_b [3];

    always_comb begin
        logic [D_W-1:0] dif;
        n_a[0] = i_req.src_x;
        n_a[1] = i_req.src_y;
        n_a[2] = i_req.src_z;
        n_b[0] = i_req.lis_x;
        n_b[1] = i_req.lis_y;
        n_b[2] = i_req.lis_z;
        for (int i = 0; i < 3; i++) begin
            dif = {n_a[i][COORD_WIDTH-1], n_a[i]} - {n_b[i][COORD_WIDTH-1], n_b[i]};
            n_gap[i] = dif[D_W-1] ? (~dif + D_W'(1)) : dif;
        end
        n_side0.rdist = i_req.ref_distance;
        n_side0.roll  = i_req.rolloff;
        n_side0.lo    = i_req.min_level;
        n_side0.hi    = i_req.max_level;
        n_side0.vol   = i_req.src_volume;
        n_side0.pan   = i_req.pan;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gap   <= n_gap;
            r_side1 <= n_side0;
        end
    end

    // Stage 2: squares.
    logic [S_W-1:0] r_sq [3];
    t_side          r_side2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= S_W'(r_gap[i]) * S_W'(r_gap[i]);
            end
            r_side2 <= r_side1;
        end
    end

    // Square root: entry 0 holds the sum, each stage settles one root bit.
    logic [S_W-1:0]  r_qs_s    [R_W+1];
    logic [RM_W-1:0] r_qs_rem  [R_W+1];
    logic [R_W-1:0]  r_qs_root [R_W+1];
    t_side           r_qs_side [R_W+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qs_s[0]    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_qs_rem[0]  <= '0;
            r_qs_root[0] <= '0;
            r_qs_side[0] <= r_side2;
        end
    end

    for (genvar gi = 0; gi < R_W; gi++) begin : g_sqrt
        logic [RM_W-1:0] n_cur;
        logic [RM_W-1:0] n_trial;
        logic            n_ge;

        always_comb begin
            n_cur   = {r_qs_rem[gi][RM_W-3:0], r_qs_s[gi][S_W-1-2*gi -: 2]};
            n_trial = RM_W'({r_qs_root[gi], 2'b01});
            n_ge    = n_cur >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qs_s[gi+1]    <= r_qs_s[gi];
                r_qs_rem[gi+1]  <= n_ge ? (n_cur - n_trial) : n_cur;
                r_qs_root[gi+1] <= {r_qs_root[gi][R_W-2:0], n_ge};
                r_qs_side[gi+1] <= r_qs_side[gi];
            end
        end
    end

    // Rolloff product beyond the reference distance.
    logic [PROD_W-1:0] r_a_prod;
    logic              r_a_gt;
    t_side             r_a_side;

    always_ff @(posedge i_clk) begin
        logic [CMP_W-1:0] d_c;
        logic [CMP_W-1:0] ref_c;
        logic [CMP_W-1:0] dif;
        if (en) begin
            d_c      = CMP_W'(r_qs_root[R_W]);
            ref_c    = CMP_W'(r_qs_side[R_W].rdist);
            dif      = d_c - ref_c;
            r_a_gt   <= d_c > ref_c;
            r_a_prod <= PROD_W'(dif[R_W-1:0]) * PROD_W'(r_qs_side[R_W].roll);
            r_a_side <= r_qs_side[R_W];
        end
    end

    // Divider: entry 0 holds numerator and divisor, one quotient bit a stage.
    logic [DIV_W-1:0] r_dv_rem  [Q_W+1];
    logic [DEN_W-1:0] r_dv_den  [Q_W+1];
    logic [Q_W-1:0]   r_dv_q    [Q_W+1];
    logic             r_dv_gt   [Q_W+1];
    t_side            r_dv_side [Q_W+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0]  <= DIV_W'({r_a_side.rdist, (8 + FRAC_BITS)'(0)});
            r_dv_den[0]  <= DEN_W'(r_a_prod) + DEN_W'({r_a_side.rdist, 8'b0});
            r_dv_q[0]    <= '0;
            r_dv_gt[0]   <= r_a_gt;
            r_dv_side[0] <= r_a_side;
        end
    end

    for (genvar gj = 0; gj < Q_W; gj++) begin : g_div
        logic [DIV_W-1:0] n_sh;
        logic             n_ge;

        always_comb begin
            n_sh = DIV_W'(r_dv_den[gj]) << (FRAC_BITS - gj);
            n_ge = r_dv_rem[gj] >= n_sh;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[gj+1]  <= n_ge ? (r_dv_rem[gj] - n_sh) : r_dv_rem[gj];
                r_dv_den[gj+1]  <= r_dv_den[gj];
                r_dv_q[gj+1]    <= {r_dv_q[gj][Q_W-2:0], n_ge};
                r_dv_gt[gj+1]   <= r_dv_gt[gj];
                r_dv_side[gj+1] <= r_dv_side[gj];
            end
        end
    end

    // Attenuation select and clamp; a zero divisor gives unity before the clamp.
    logic [G_W-1:0] r_att;
    t_side          r_c_side;

    always_ff @(posedge i_clk) begin
        logic [G_W-1:0] att;
        if (en) begin
            att = (!r_dv_gt[Q_W] || (r_dv_den[Q_W] == '0)) ? UNITY : r_dv_q[Q_W];
            if (att < r_dv_side[Q_W].lo) begin
                att = r_dv_side[Q_W].lo;
            end
            if (att > r_dv_side[Q_W].hi) begin
                att = r_dv_side[Q_W].hi;
            end
            r_att    <= att;
            r_c_side <= r_dv_side[Q_W];
        end
    end

    // Volume and master gains, one multiply per stage.
    logic [T1_W-1:0] r_t1;
    logic [T2_W-1:0] r_t2;
    logic [T3_W-1:0] r_t3;
    logic [psg_pkg::PAN_W-1:0] r_pan1;
    logic [psg_pkg::PAN_W-1:0] r_pan2;
    logic [psg_pkg::PAN_W-1:0] r_pan3;

    always_ff @(posedge i_clk) begin
        logic [2*G_W-1:0]     p1;
        logic [T1_W+G_W-1:0]  p2;
        logic [T2_W+G_W-1:0]  p3;
        if (en) begin
            p1     = (2*G_W)'(r_c_side.vol) * (2*G_W)'(r_att);
            r_t1   <= p1[FRAC_BITS +: T1_W];
            r_pan1 <= r_c_side.pan;
            p2     = (T1_W+G_W)'(r_t1) * (T1_W+G_W)'(r_mvol);
            r_t2   <= p2[FRAC_BITS +: T2_W];
            r_pan2 <= r_pan1;
            p3     = (T2_W+G_W)'(r_t2) * (T2_W+G_W)'(r_mlev);
            r_t3   <= p3[FRAC_BITS +: T3_W];
            r_pan3 <= r_pan2;
        end
    end

    // Audible test and pan multiplies.
    logic [T3_W:0] r_gl;
    logic [T3_W:0] r_gr;
    logic          r_aud;

    always_ff @(posedge i_clk) begin
        logic [A_W-1:0]              ap;
        logic [psg_pkg::PG_W:0]      pan_s;
        logic [psg_pkg::PG_W:0]      pl18;
        logic [psg_pkg::PG_W:0]      pr18;
        logic [psg_pkg::PG_W-1:0]    pl;
        logic [psg_pkg::PG_W-1:0]    pr;
        logic [GP_W-1:0]             gl;
        logic [GP_W-1:0]             gr;
        if (en) begin
            ap    = A_W'(r_t3) * A_W'(psg_pkg::AUD_SCALE);
            r_aud <= ap >= A_W'(UNITY);
            pan_s = {{2{r_pan3[psg_pkg::PAN_W-1]}}, r_pan3};
            pl18  = r_stereo ? (psg_pkg::PAN_ONE - pan_s) : psg_pkg::PAN_ONE;
            pr18  = r_stereo ? (psg_pkg::PAN_ONE + pan_s) : psg_pkg::PAN_ONE;
            pl    = pl18[psg_pkg::PG_W-1:0];
            pr    = pr18[psg_pkg::PG_W-1:0];
            gl    = GP_W'(r_t3) * GP_W'(pl);
            gr    = GP_W'(r_t3) * GP_W'(pr);
            r_gl  <= gl[psg_pkg::PAN_SHIFT +: T3_W+1];
            r_gr  <= gr[psg_pkg::PAN_SHIFT +: T3_W+1];
        end
    end

    // Output register: saturate, and silence sources below the threshold.
    logic [G_W-1:0] r_out_l;
    logic [G_W-1:0] r_out_r;
    logic           r_out_aud;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_aud <= r_aud;
            if (!r_aud) begin
                r_out_l <= '0;
                r_out_r <= '0;
            end else begin
                r_out_l <= (r_gl > (T3_W+1)'(MAX_GAIN)) ? MAX_GAIN : r_gl[G_W-1:0];
                r_out_r <= (r_gr > (T3_W+1)'(MAX_GAIN)) ? MAX_GAIN : r_gr[G_W-1:0];
            end
        end
    end

    assign o_res.valid      = r_v[NSTG-1];
    assign o_res.left_gain  = r_out_l;
    assign o_res.right_gain = r_out_r;
    assign o_res.audible    = r_out_aud;

endmodule

`default_nettype wire

// File: hw/rtl/psg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "positional_source_gain_macros.svh"

module psg_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [FRAC_BITS:0] i_left,
    input wire logic [FRAC_BITS:0] i_right,
    input wire logic               i_audible
);

    localparam logic [FRAC_BITS:0] MAX_GAIN = (FRAC_BITS+1)'(3 * (2 ** (FRAC_BITS - 1)));

    // A stalled result holds.
    `PSG_ASSERT(a_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left) && $stable(i_right) && $stable(i_audible), "stalled result changed")

    // Silent sources carry zero gains.
    `PSG_ASSERT(a_quiet, i_out_valid && !i_audible |-> i_left == '0 && i_right == '0, "inaudible result has gain")

    // Gains never pass the saturation limit.
    `PSG_ASSERT(a_sat, i_out_valid |-> i_left <= MAX_GAIN && i_right <= MAX_GAIN, "gain above limit")

    // A stalled output stops new requests.
    `PSG_ASSERT(a_stall, i_out_valid && !i_out_ready |-> !i_in_ready, "request taken while output stalled")

    // Reset empties the pipeline.
    `PSG_ASSERT_RST(a_rst, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind positional_source_gain psg_checker #(.FRAC_BITS(FRAC_BITS)) u_psg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_left      (o_res.left_gain),
    .i_right     (o_res.right_gain),
    .i_audible   (o_res.audible)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = CW + FB + 13;
    localparam int MAX_CYC  = 600000;
    localparam logic [63:0] UNITY    = 64'd65536;
    localparam logic [63:0] MAX_GAIN = 64'd98304;
    // Index past the last register; writes to it must be ignored.
    localparam logic [psg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] src_x, src_y, src_z;
        logic signed [CW-1:0] lis_x, lis_y, lis_z;
        logic [psg_pkg::REF_W-1:0]  ref_distance;
        logic [psg_pkg::ROLL_W-1:0] rolloff;
        logic [FB:0]          min_level, max_level, src_volume;
        logic signed [psg_pkg::PAN_W-1:0] pan;
    } t_source;

    typedef struct packed {
        logic [FB:0] left_gain;
        logic [FB:0] right_gain;
        logic        audible;
    } t_gains;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [psg_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [FB:0] i_cfg_data = '0;

    psg_in_if  #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) req_if ();
    psg_out_if #(.FRAC_BITS(FB)) res_if ();

    positional_source_gain #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_res     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Local copy of the master gains and stereo mode.
    logic [63:0] mvol_shadow = UNITY;
    logic [63:0] mlev_shadow = UNITY;
    logic        stereo_shadow = 1'b1;

    t_source sources_pending[$];
    t_gains  gains_due[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_mode = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected gains for one source under the current master settings.
    function automatic t_gains predict_gains(t_source s);
        logic [63:0]  gap, root, cand, diff, ref_q, prod, den, att, t, pl, pr, gl, gr;
        logic [127:0] sumsq, sq, wide;
        logic [CW-1:0] a[3], b[3];
        t_gains g;
        a = '{s.src_x, s.src_y, s.src_z};
        b = '{s.lis_x, s.lis_y, s.lis_z};
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            gap = {{32{a[i][CW-1]}}, a[i]} - {{32{b[i][CW-1]}}, b[i]};
            if (gap[63]) gap = -gap;
            sumsq = sumsq + {64'd0, gap} * {64'd0, gap};
        end
        root = '0;
        for (int k = 62; k >= 0; k--) begin
            cand = root | (64'd1 << k);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= sumsq) root = cand;
        end
        ref_q = {33'd0, s.ref_distance};
        if (root <= ref_q) begin
            att = UNITY;
        end else begin
            diff = root - ref_q;
            wide = {64'd0, diff} * {112'd0, s.rolloff};
            prod = (wide[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
            wide = {64'd0, prod} + {64'd0, ref_q << 8};
            den = (wide[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
            // Zero divisor means no attenuation, so the gain is unity before the limits.
            att = (den == 0) ? UNITY : (ref_q << 24) / den;
        end
        if (att < {47'd0, s.min_level}) att = {47'd0, s.min_level};
        if (att > {47'd0, s.max_level}) att = {47'd0, s.max_level};
        t = ({47'd0, s.src_volume} * att) >> FB;
        t = (t * mvol_shadow) >> FB;
        t = (t * mlev_shadow) >> FB;
        if (t * 64'd10000 < UNITY) begin
            g = '0;
        end else begin
            if (stereo_shadow) begin
                pl = UNITY - {{48{s.pan[15]}}, s.pan};
                pr = UNITY + {{48{s.pan[15]}}, s.pan};
            end else begin
                pl = UNITY;
                pr = UNITY;
            end
            gl = (t * pl) >> 16;
            gr = (t * pr) >> 16;
            if (gl > MAX_GAIN) gl = MAX_GAIN;
            if (gr > MAX_GAIN) gr = MAX_GAIN;
            g.left_gain = gl[FB:0];
            g.right_gain = gr[FB:0];
            g.audible = 1'b1;
        end
        return g;
    endfunction

    function automatic logic [CW-1:0] near_coord(logic [CW-1:0] base);
        int sh;
        logic [CW-1:0] off;
        sh = $urandom_range(2, 24);
        off = $urandom_range(0, (1 << sh) - 1);
        return $urandom_range(0, 1) ? base + off : base - off;
    endfunction

    // Mostly nearby sources with realistic limits, some full-range noise.
    function automatic t_source random_source();
        t_source s;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            s.lis_x = $urandom; s.lis_y = $urandom; s.lis_z = $urandom;
            s.src_x = $urandom; s.src_y = $urandom; s.src_z = $urandom;
            s.ref_distance = (psg_pkg::REF_W)'($urandom);
        end else begin
            s.lis_x = $urandom; s.lis_y = $urandom; s.lis_z = $urandom;
            if (kind < 4) begin
                s.lis_x = s.lis_x >>> 8; s.lis_y = s.lis_y >>> 8; s.lis_z = s.lis_z >>> 8;
            end
            s.src_x = near_coord(s.lis_x);
            s.src_y = near_coord(s.lis_y);
            s.src_z = near_coord(s.lis_z);
            s.ref_distance = (psg_pkg::REF_W)'($urandom_range(0, 1 << $urandom_range(8, 25)));
        end
        case ($urandom_range(0, 5))
            0: s.rolloff = 16'd0;
            1: s.rolloff = 16'd256;
            default: s.rolloff = (psg_pkg::ROLL_W)'($urandom);
        endcase
        s.min_level = (FB+1)'($urandom_range(0, 65536));
        s.max_level = (FB+1)'($urandom_range(0, 65536));
        // Keep limits ordered most of the time.
        if (kind > 1 && s.min_level > s.max_level) begin
            s.max_level = s.min_level;
            s.min_level = (FB+1)'($urandom_range(0, 16384));
        end
        s.src_volume = ($urandom_range(0, 7) == 0) ? (FB+1)'($urandom_range(0, 8)) :
                       (FB+1)'($urandom_range(0, 65536));
        s.pan = (psg_pkg::PAN_W)'($urandom);
        return s;
    endfunction

    function automatic t_source make_source(logic [CW-1:0] sx, logic [CW-1:0] lx,
                                            logic [psg_pkg::REF_W-1:0] rd,
                                            logic [psg_pkg::ROLL_W-1:0] ro,
                                            logic [FB:0] lo, logic [FB:0] hi,
                                            logic [FB:0] vol, logic [psg_pkg::PAN_W-1:0] pn);
        t_source s;
        s.src_x = sx; s.src_y = sx; s.src_z = sx;
        s.lis_x = lx; s.lis_y = lx; s.lis_z = lx;
        s.ref_distance = rd; s.rolloff = ro;
        s.min_level = lo; s.max_level = hi; s.src_volume = vol; s.pan = pn;
        return s;
    endfunction

    // Append one source to the pending queue.
    task automatic add_source(input t_source s);
        sources_pending.insert(sources_pending.size(), s);
    endtask

    task automatic write_reg(input logic [psg_pkg::CFG_IDX_W-1:0] idx, input logic [FB:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            psg_pkg::CFG_MVOL:   mvol_shadow = {47'd0, val};
            psg_pkg::CFG_MLEV:   mlev_shadow = {47'd0, val};
            psg_pkg::CFG_STEREO: stereo_shadow = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sources_pending.size() != 0 || req_if.valid || gains_due.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) add_source(random_source());
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_if.valid <= 1'b0;
            end else if (sources_pending.size() != 0) begin
                t_source s;
                s = sources_pending.pop_front();
                req_if.valid <= 1'b1;
                req_if.src_x <= s.src_x; req_if.src_y <= s.src_y; req_if.src_z <= s.src_z;
                req_if.lis_x <= s.lis_x; req_if.lis_y <= s.lis_y; req_if.lis_z <= s.lis_z;
                req_if.ref_distance <= s.ref_distance;
                req_if.rolloff <= s.rolloff;
                req_if.min_level <= s.min_level;
                req_if.max_level <= s.max_level;
                req_if.src_volume <= s.src_volume;
                req_if.pan <= s.pan;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result ready: alternates between always ready, random stalls and long stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        if (!i_rst_n) res_if.ready <= 1'b0;
        else case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 3) != 0);
            default: res_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
        if (cycle_count >= MAX_CYC) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Record the expected gains of each accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            t_source s;
            s.src_x = req_if.src_x; s.src_y = req_if.src_y; s.src_z = req_if.src_z;
            s.lis_x = req_if.lis_x; s.lis_y = req_if.lis_y; s.lis_z = req_if.lis_z;
            s.ref_distance = req_if.ref_distance;
            s.rolloff = req_if.rolloff;
            s.min_level = req_if.min_level;
            s.max_level = req_if.max_level;
            s.src_volume = req_if.src_volume;
            s.pan = req_if.pan;
            gains_due.insert(gains_due.size(), predict_gains(s));
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            t_gains want;
            if (gains_due.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected result at cycle %0d", cycle_count);
            end else begin
                want = gains_due.pop_front();
                if (res_if.left_gain !== want.left_gain || res_if.right_gain !== want.right_gain
                        || res_if.audible !== want.audible) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: left %0d/%0d right %0d/%0d audible %0b/%0b",
                                 res_if.left_gain, want.left_gain, res_if.right_gain,
                                 want.right_gain, res_if.audible, want.audible);
                end
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.src_x = '0; req_if.src_y = '0; req_if.src_z = '0;
        req_if.lis_x = '0; req_if.lis_y = '0; req_if.lis_z = '0;
        req_if.ref_distance = '0; req_if.rolloff = '0;
        req_if.min_level = '0; req_if.max_level = '0;
        req_if.src_volume = '0; req_if.pan = '0;
        res_if.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: coincident source, extreme positions, zero divisor,
        // inverted limits, silent source, pan extremes.
        add_source(make_source(0, 0, 0, 0, 0, 65536, 65536, 0));
        add_source(make_source(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF,
                               0, 65536, 65536, 16'h8000));
        add_source(make_source(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                               16'hFFFF, 65536, 65536, 65536, 16'h7FFF));
        add_source(make_source(32'h0010_0000, 0, 0, 0, 100, 40000, 65536, 0));
        add_source(make_source(32'h0010_0000, 0, 31'h10000, 256, 50000, 20000,
                               65536, 16'h4000));
        add_source(make_source(32'h0005_0000, 0, 31'h10000, 256, 0, 65536,
                               65536, 16'hC000));
        add_source(make_source(32'h0005_0000, 0, 31'h10000, 256, 0, 65536,
                               0, 0));
        add_source(make_source(32'h0005_0000, 0, 31'h10000, 256, 0, 65536,
                               7, 0));
        add_source(make_source(32'h0005_0000, 0, 31'h10000, 256, 0, 65536,
                               65536, 16'h7FFF));
        add_source(make_source(32'hFFF0_0000, 32'h0001_0000, 31'h20000,
                               16'h0080, 0, 65536, 65536, 16'h8001));
        add_source(make_source(32'h0100_0000, 0, 31'h7FFF_FFFF, 0, 0, 0,
                               65536, 0));
        add_source(make_source(32'h0000_0001, 0, 0, 16'h0001, 0, 65536,
                               65536, 16'hFFFF));
        queue_random(8);
        drain();

        // Extremes of the master settings, then random ones.
        write_reg(psg_pkg::CFG_MVOL, 0);
        write_reg(psg_pkg::CFG_MLEV, 0);
        write_reg(psg_pkg::CFG_STEREO, 0);
        queue_random(60);
        drain();
        write_reg(psg_pkg::CFG_MVOL, 65536);
        write_reg(psg_pkg::CFG_MLEV, 65536);
        queue_random(250);
        drain();
        write_reg(psg_pkg::CFG_STEREO, 1);
        write_reg(CFG_SPARE, 17'h1FFFF);
        queue_random(350);
        drain();
        for (int p = 0; p < 4; p++) begin
            write_reg(psg_pkg::CFG_MVOL, (FB+1)'($urandom_range(0, 65536)));
            write_reg(psg_pkg::CFG_MLEV, (FB+1)'($urandom_range(0, 65536)));
            write_reg(psg_pkg::CFG_STEREO, (FB+1)'($urandom_range(0, 1)));
            queue_random(160);
            drain();
        end

        if (mismatch_count == 0 && gains_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
